### hdl/t8c_pkg.sv
// shared types and codes for the tiny 8-bit processor step block
// no dependencies
package t8c_pkg;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_SETPC = 2'd1;
    localparam logic [1:0] FUNC_EXEC  = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    localparam logic [3:0] OP_NOP   = 4'h0;
    localparam logic [3:0] OP_LOAD  = 4'h1;
    localparam logic [3:0] OP_STORE = 4'h2;
    localparam logic [3:0] OP_ADD   = 4'h3;
    localparam logic [3:0] OP_SUB   = 4'h4;
    localparam logic [3:0] OP_JMP   = 4'h5;
    localparam logic [3:0] OP_JZ    = 4'h6;
    localparam logic [3:0] OP_CALL  = 4'h7;
    localparam logic [3:0] OP_RET   = 4'h8;
    localparam logic [3:0] OP_IN    = 4'h9;
    localparam logic [3:0] OP_OUT   = 4'hA;
    localparam logic [3:0] OP_DRD   = 4'hB;
    localparam logic [3:0] OP_DWR   = 4'hC;
    localparam logic [3:0] OP_HALT  = 4'hF;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_HALT = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // one result item
    typedef struct packed {
        logic [7:0]  zero_flag_pad;
        logic [15:0] next_pc;
        logic [7:0]  read_data;
        logic [7:0]  out_value;
        logic [1:0]  out_register;
        logic        out_valid;
        logic [1:0]  status;
    } t8c_res_t;

endpackage

### hdl/tiny_8bit_cpu_step.sv
// top level of the tiny 8-bit processor step block: sequencer, registers, memories
// depends on t8c_pkg and t8c_ram
//
// Each input transfer (func, address, data) gives one result transfer. After reset
// the block sweeps both memories to zero, one byte per cycle, over every address of
// the wider of the two address widths, and takes no item meanwhile. A memory write or
// set-PC request passes S_REQ and S_DONE; a read request passes S_REQ, S_OUT and
// S_DONE. An executed instruction fetches its opcode in S_REQ, decodes it in S_OPC and
// then, one access of the single-ported main memory or of the disk at a time, passes
// S_B1 and S_B2 for operand bytes, S_PSH2 or S_POP1 and S_POP2 for stack bytes and
// S_DISK for DISK_READ as it needs; the first push of CALL shares a cycle with its
// last operand fetch. A finished result sits in an output register, so the next request
// is taken while it waits; that request then holds in S_DONE until the result is taken.
module tiny_8bit_cpu_step #(
    parameter int MEM_DEPTH  = 65536,
    parameter int DISK_DEPTH = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // func[1:0], address[17:2], data[25:18], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // status, out_valid, out_register, out_value,
                                  // read_data, next_pc, zero_flag, zeros
);
    import t8c_pkg::*;

    localparam int MAW = $clog2(MEM_DEPTH);
    localparam int DAW = $clog2(DISK_DEPTH);
    localparam int CW  = (MAW > DAW) ? MAW : DAW;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_REQ  = 4'd2;
    localparam logic [3:0] S_OPC  = 4'd3;
    localparam logic [3:0] S_B1   = 4'd4;
    localparam logic [3:0] S_B2   = 4'd5;
    localparam logic [3:0] S_POP1 = 4'd6;
    localparam logic [3:0] S_POP2 = 4'd7;
    localparam logic [3:0] S_DISK = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;
    localparam logic [3:0] S_PSH2 = 4'd11;

    logic [3:0]  state_reg, state_next;
    logic [CW:0] clr_reg, clr_next;
    logic [7:0]  rf_reg [4];
    logic [7:0]  rf_next [4];
    logic [15:0] pc_reg, pc_next;
    logic [7:0]  sp_reg, sp_next;
    logic        z_reg, z_next;
    logic [1:0]  func_reg, func_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  data_reg, data_next;
    logic [7:0]  ins_reg, ins_next;
    logic [7:0]  b1_reg, b1_next;
    t8c_res_t    wres_reg, wres_next;
    t8c_res_t    res_reg, res_next;
    logic        mv_reg, mv_next;

    logic           m_we, d_we;
    logic [MAW-1:0] m_addr;
    logic [DAW-1:0] d_addr;
    logic [7:0]     m_wd, d_wd, m_rd, d_rd;
    logic [3:0]     op;
    logic [1:0]     rn;
    logic [7:0]     rnv, rmv, alu;
    logic [7:0]     sp_inc;
    logic [15:0]    tgt;

    t8c_ram #(.DEPTH(MEM_DEPTH)) u_mem (
        .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd)
    );
    t8c_ram #(.DEPTH(DISK_DEPTH)) u_disk (
        .clk(clk), .we(d_we), .addr(d_addr), .wdata(d_wd), .rdata(d_rd)
    );

    assign op  = ins_reg[7:4];
    assign rn  = ins_reg[1:0];
    assign rnv = rf_reg[rn];
    assign rmv = rf_reg[m_rd[1:0]];
    assign alu = (op == OP_ADD) ? rnv + rmv : rnv - rmv;

    // stack pointer step wraps within 8 bits, word target from two fetched bytes
    assign sp_inc = sp_reg + 8'd1;
    assign tgt    = {m_rd, b1_reg};

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = {2'd0, res_reg.zero_flag_pad[0], res_reg.next_pc,
                       res_reg.read_data, res_reg.out_value,
                       res_reg.out_register, res_reg.out_valid, res_reg.status};

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        rf_next    = rf_reg;
        pc_next    = pc_reg;
        sp_next    = sp_reg;
        z_next     = z_reg;
        func_next  = func_reg;
        addr_next  = addr_reg;
        data_next  = data_reg;
        ins_next   = ins_reg;
        b1_next    = b1_reg;
        wres_next  = wres_reg;
        res_next   = res_reg;
        mv_next    = mv_reg;
        m_we   = 1'b0;
        d_we   = 1'b0;
        m_addr = pc_reg[MAW-1:0];
        d_addr = tgt[DAW-1:0];
        m_wd   = rnv;
        d_wd   = rnv;
        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end
        case (state_reg)
            S_CLR:
            begin
                m_we   = 1'b1;
                d_we   = 1'b1;
                m_wd   = 8'd0;
                d_wd   = 8'd0;
                m_addr = clr_reg[MAW-1:0];
                d_addr = clr_reg[DAW-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (CW+1)'((1 << CW) - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    func_next  = s_tdata[1:0];
                    addr_next  = s_tdata[17:2];
                    data_next  = s_tdata[25:18];
                    state_next = S_REQ;
                end
            end
            S_REQ:
            begin
                wres_next = '0;
                case (func_reg)
                    FUNC_WRITE:
                    begin
                        m_we   = 1'b1;
                        m_addr = addr_reg[MAW-1:0];
                        m_wd   = data_reg;
                        state_next = S_DONE;
                    end
                    FUNC_SETPC:
                    begin
                        pc_next    = addr_reg;
                        state_next = S_DONE;
                    end
                    FUNC_READ:
                    begin
                        m_addr     = addr_reg[MAW-1:0];
                        state_next = S_OUT;
                    end
                    default:
                    begin
                        pc_next    = pc_reg + 16'd1;
                        state_next = S_OPC;
                    end
                endcase
            end
            S_OUT:
            begin
                wres_next.read_data = m_rd;
                state_next = S_DONE;
            end
            S_OPC:
            begin
                ins_next   = m_rd;
                state_next = S_DONE;
                case (m_rd[7:4])
                    OP_NOP: ;
                    OP_HALT: wres_next.status = ST_HALT;
                    OP_IN:
                    begin
                        rf_next[m_rd[1:0]] = data_reg;
                        z_next = (data_reg == 8'd0);
                    end
                    OP_OUT:
                    begin
                        wres_next.out_valid    = 1'b1;
                        wres_next.out_register = m_rd[1:0];
                        wres_next.out_value    = rf_reg[m_rd[1:0]];
                    end
                    OP_RET:
                    begin
                        m_addr     = MAW'(sp_inc);
                        sp_next    = sp_inc;
                        state_next = S_POP1;
                    end
                    OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_JMP, OP_JZ, OP_CALL,
                    OP_DRD, OP_DWR:
                    begin
                        pc_next    = pc_reg + 16'd1;
                        state_next = S_B1;
                    end
                    default: wres_next.status = ST_BAD;
                endcase
            end
            S_B1:
            begin
                state_next = S_DONE;
                case (op)
                    OP_LOAD:
                    begin
                        rf_next[rn] = m_rd;
                        z_next = (m_rd == 8'd0);
                    end
                    OP_STORE:
                    begin
                        m_we   = 1'b1;
                        m_addr = MAW'(m_rd);
                    end
                    OP_ADD, OP_SUB:
                    begin
                        rf_next[rn] = alu;
                        z_next = (alu == 8'd0);
                    end
                    default:
                    begin
                        b1_next    = m_rd;
                        pc_next    = pc_reg + 16'd1;
                        state_next = S_B2;
                    end
                endcase
            end
            S_B2:
            begin
                state_next = S_DONE;
                case (op)
                    OP_JMP: pc_next = tgt;
                    OP_JZ:
                    begin
                        if (z_reg)
                        begin
                            pc_next = tgt;
                        end
                    end
                    OP_CALL:
                    begin
                        // push high byte, remember target
                        m_we    = 1'b1;
                        m_addr  = MAW'(sp_reg);
                        m_wd    = pc_reg[15:8];
                        sp_next = sp_reg - 8'd1;
                        addr_next  = tgt;
                        state_next = S_PSH2;
                    end
                    OP_DRD: state_next = S_DISK;
                    default: d_we = 1'b1;
                endcase
            end
            S_PSH2:
            begin
                m_we    = 1'b1;
                m_addr  = MAW'(sp_reg);
                m_wd    = pc_reg[7:0];
                sp_next = sp_reg - 8'd1;
                pc_next = addr_reg;
                state_next = S_DONE;
            end
            S_DISK:
            begin
                rf_next[rn] = d_rd;
                z_next = (d_rd == 8'd0);
                state_next = S_DONE;
            end
            S_POP1:
            begin
                b1_next = m_rd;
                m_addr  = MAW'(sp_inc);
                sp_next = sp_inc;
                state_next = S_POP2;
            end
            S_POP2:
            begin
                pc_next    = tgt;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!mv_reg || m_tready)
                begin
                    res_next               = wres_reg;
                    res_next.next_pc       = pc_reg;
                    res_next.zero_flag_pad = {7'd0, z_reg};
                    mv_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            pc_reg    <= '0;
            sp_reg    <= 8'hFF;
            z_reg     <= 1'b0;
            mv_reg    <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                rf_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pc_reg    <= pc_next;
            sp_reg    <= sp_next;
            z_reg     <= z_next;
            mv_reg    <= mv_next;
            rf_reg    <= rf_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        addr_reg <= addr_next;
        data_reg <= data_next;
        ins_reg  <= ins_next;
        b1_reg   <= b1_next;
        wres_reg <= wres_next;
        res_reg  <= res_next;
    end

`ifndef SYNTHESIS
    // no item is taken during the clearing sweep
    a_no_take_clr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLR |-> !s_tready)
        else $error("item taken during clear");
    // a pending result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    // result status is never the undefined code
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("bad status");
`endif

endmodule

### hdl/t8c_ram.sv
// single-port byte memory with registered read data
// depends on nothing
module t8c_ram #(
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [7:0]               wdata,
    output logic [7:0]               rdata
);
    logic [7:0] mem [DEPTH];

    // one access per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
